FILE: sv/djq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djq_pkg
// Shared types and codes for the deadline ordered job queue.
// ----------------------------------------------------------------------------
package djq_pkg;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_JOB   = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    // deadline reported for a job whose deadline has passed
    localparam logic signed [31:0] DL_PASSED = -32'sd1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] job_id;
        logic [30:0] job_deadline;
        logic [30:0] current_step;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        out_job_id;
        logic signed [31:0] out_deadline;
        logic               is_last;
    } t_out_item;

    // contents of one table slot
    typedef struct packed {
        logic [15:0] job;
        logic [30:0] deadline;
    } t_cell_data;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // shift-insert the new job
        logic shift;  // move every slot one place toward the head
    } t_cell_ctl;

endpackage

FILE: sv/deadline_ordered_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_ordered_job_queue
// Earliest-deadline-first job table built as a row of shift-insert cells.
// ----------------------------------------------------------------------------
// On an insert every cell compares the new deadline with its own in
// parallel and the later part of the row shifts one place, so inserts
// may arrive back to back while the output register is free. A drain of n
// stored jobs gives n items, one per cycle while the output is not
// stalled, from the head cell through the single output register; the
// input is stalled until the last one is registered. A drain of an empty
// table, or an insert into a full table, gives one item. Equal deadlines
// keep arrival order. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module deadline_ordered_job_queue
    import djq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_draining;
    logic             n_draining;
    logic [30:0]      r_now;
    logic [30:0]      n_now;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic       out_free;
    logic       in_acc;
    logic       full;
    t_cell_ctl  ctl;
    t_cell_data new_data;
    t_cell_data cell_q  [QUEUE_DEPTH];
    logic       cell_gt [QUEUE_DEPTH];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_draining || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));

    assign new_data.job      = i_in_item.job_id;
    assign new_data.deadline = i_in_item.job_deadline;

    // cell commands
    always_comb begin
        ctl.ins   = in_acc && (i_in_item.req_type == REQ_INSERT) && !full;
        ctl.shift = r_draining && out_free;
    end

    // row of cells
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_cell_data left_d;
        t_cell_data right_d;
        logic       left_gt;
        logic       occ;

        assign occ = (CNT_W'(k) < r_count);

        if (k == 0) begin : g_head
            assign left_d  = new_data;
            assign left_gt = 1'b0;
        end else begin : g_body
            assign left_d  = cell_q[k-1];
            assign left_gt = cell_gt[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_mid
            assign right_d = cell_q[k+1];
        end

        djq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_occ     (occ),
            .i_new     (new_data),
            .i_left    (left_d),
            .i_left_gt (left_gt),
            .i_right   (right_d),
            .o_data    (cell_q[k]),
            .o_gt      (cell_gt[k])
        );
    end

    // control and output register
    always_comb begin
        n_count     = r_count;
        n_draining  = r_draining;
        n_now       = r_now;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (r_draining) begin
            if (out_free) begin
                n_out_valid        = 1'b1;
                n_out.status       = ST_JOB;
                n_out.out_job_id   = cell_q[0].job;
                n_out.out_deadline = (r_now > cell_q[0].deadline) ? DL_PASSED
                                   : $signed({1'b0, cell_q[0].deadline});
                n_out.is_last      = (r_count == CNT_W'(1));
                n_count            = r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    n_draining = 1'b0;
                end
            end
        end else if (in_acc) begin
            if (i_in_item.req_type == REQ_INSERT) begin
                if (full) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = ST_DROP;
                    n_out.out_job_id   = i_in_item.job_id;
                    n_out.out_deadline = $signed({1'b0, i_in_item.job_deadline});
                    n_out.is_last      = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (r_count == '0) begin
                n_out_valid        = 1'b1;
                n_out.status       = ST_EMPTY;
                n_out.out_job_id   = '0;
                n_out.out_deadline = '0;
                n_out.is_last      = 1'b1;
            end else begin
                n_draining = 1'b1;
                n_now      = i_in_item.current_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_draining  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_draining  <= n_draining;
            r_out_valid <= n_out_valid;
        end
        r_now <= n_now;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: sv/djq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djq_cell
// One slot of the sorted table. On insert it keeps its job, takes the new
// job, or takes its left neighbor's job; on drain it takes its right one.
// ----------------------------------------------------------------------------
module djq_cell
    import djq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_occ,        // slot holds a stored job
    input  t_cell_data i_new,        // job being inserted
    input  t_cell_data i_left,       // left neighbor's contents
    input  logic       i_left_gt,    // left neighbor moves right on insert
    input  t_cell_data i_right,      // right neighbor's contents
    output t_cell_data o_data,
    output logic       o_gt
);

    t_cell_data r_data;
    t_cell_data n_data;

    // stored job lies strictly after the new one
    assign o_gt = i_occ && (i_new.deadline < r_data.deadline);

    // next slot contents
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_right;
        end else if (i_ctl.ins && (o_gt || !i_occ)) begin
            n_data = i_left_gt ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: sv/djq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djq_checker
// Port-level checks on the deadline ordered job queue, bound to the top.
// ----------------------------------------------------------------------------
module djq_checker
    import djq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_stall,
    input logic      o_out_valid,
    input t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    // only defined status codes appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_JOB ||
                         o_out_item.status == ST_EMPTY ||
                         o_out_item.status == ST_DROP))
        else $error("undefined status code");

    // empty and drop results stand alone
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_EMPTY ||
                        o_out_item.status == ST_DROP) |-> o_out_item.is_last)
        else $error("single result not marked last");

    // empty result carries zero fields
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_EMPTY |->
            o_out_item.out_job_id == '0 && o_out_item.out_deadline == '0)
        else $error("empty result has nonzero fields");

endmodule

bind deadline_ordered_job_queue djq_checker u_djq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item)
);
